/* hw/rtl/efc_pkg.sv */
package efc_pkg;

  // Width of the stored previous readings
  localparam int unsigned TEMP_BITS = 16;

  localparam int unsigned TEMP_W   = 15;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned THR_W    = 14;
  localparam int unsigned CALC_W   = ((TEMP_BITS > TEMP_W) ? TEMP_BITS : TEMP_W) + 3;
  localparam int unsigned CODE_X_W = CODE_W + 2;

  localparam int unsigned APB_DW   = 32;
  localparam int unsigned REG_N    = 8;
  localparam int unsigned REG_IW   = $clog2(REG_N);
  localparam int unsigned APB_AW   = REG_IW + 2;

  typedef logic signed [TEMP_W-1:0]    temp_t;
  typedef logic signed [TEMP_BITS-1:0] prev_temp_t;
  typedef logic [CODE_W-1:0]           code_t;
  typedef logic [THR_W-1:0]            thr_t;

  typedef enum logic [REG_IW-1:0] {
    RegSetpoint   = 3'd0,
    RegFanOnCode  = 3'd1,
    RegFanMaxCode = 3'd2,
    RegSensorFloor = 3'd3,
    RegTrendStep  = 3'd4,
    RegOverMargin = 3'd5,
    RegSpreadHigh = 3'd6,
    RegSpreadLow  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    temp_t setpoint;
    code_t fan_on_code;
    code_t fan_max_code;
    temp_t sensor_floor;
    thr_t  trend_step;
    thr_t  over_margin;
    thr_t  spread_high;
    thr_t  spread_low;
  } efc_cfg_t;

  localparam temp_t RST_SETPOINT     = 15'sd2100;
  localparam code_t RST_FAN_ON_CODE  = 8'd253;
  localparam code_t RST_FAN_MAX_CODE = 8'd254;
  localparam temp_t RST_SENSOR_FLOOR = -15'sd9500;
  localparam thr_t  RST_TREND_STEP   = 14'd20;
  localparam thr_t  RST_OVER_MARGIN  = 14'd300;
  localparam thr_t  RST_SPREAD_HIGH  = 14'd500;
  localparam thr_t  RST_SPREAD_LOW   = 14'd300;

endpackage

/* hw/rtl/efc_in_if.sv */
interface efc_in_if;
  import efc_pkg::*;

  logic  valid;
  logic  ready;
  temp_t top_temp;
  temp_t bottom_temp;

  modport source (output valid, output top_temp, output bottom_temp, input ready);
  modport sink (input valid, input top_temp, input bottom_temp, output ready);
endinterface

/* hw/rtl/efc_out_if.sv */
interface efc_out_if;
  import efc_pkg::*;

  logic  valid;
  logic  ready;
  code_t inlet_code;
  code_t outlet_code;
  logic  inlet_changed;
  logic  outlet_changed;
  logic  sensor_error;

  modport source (output valid, output inlet_code, output outlet_code, output inlet_changed,
                  output outlet_changed, output sensor_error, input ready);
  modport sink (input valid, input inlet_code, input outlet_code, input inlet_changed,
                input outlet_changed, input sensor_error, output ready);
endinterface

/* hw/rtl/efc_core.sv */
module efc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  efc_pkg::efc_cfg_t cfg_i,
  efc_in_if.sink            in_i,
  efc_out_if.source         out_o
);
  import efc_pkg::*;

  typedef logic signed [CALC_W-1:0] calc_t;
  typedef logic [CODE_X_W-1:0]      code_x_t;

  logic       s1_valid_q;
  temp_t      s1_top_q, s1_bot_q;
  prev_temp_t prev_top_q, prev_bot_q;
  code_t      prev_inlet_q, prev_outlet_q;

  logic  out_valid_q;
  code_t out_inlet_q, out_outlet_q;
  logic  out_inlet_chg_q, out_outlet_chg_q, out_err_q;

  logic adv;

  calc_t top_x, bot_x, floor_x, setp_x, ptop_x, pbot_x;
  calc_t trend_x, over_x, shigh_x, slow_x;
  calc_t excess, delta, spread, growth;
  code_x_t on_x, max_x, prev_in_x, prev_out_x, inl, outl;
  logic  err;
  code_t inlet_new, outlet_new;

  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  always_comb begin
    top_x   = CALC_W'(s1_top_q);
    bot_x   = CALC_W'(s1_bot_q);
    floor_x = CALC_W'(cfg_i.sensor_floor);
    setp_x  = CALC_W'(cfg_i.setpoint);
    ptop_x  = CALC_W'(prev_top_q);
    pbot_x  = CALC_W'(prev_bot_q);
    trend_x = CALC_W'(cfg_i.trend_step);
    over_x  = CALC_W'(cfg_i.over_margin);
    shigh_x = CALC_W'(cfg_i.spread_high);
    slow_x  = CALC_W'(cfg_i.spread_low);

    on_x       = CODE_X_W'(cfg_i.fan_on_code);
    max_x      = CODE_X_W'(cfg_i.fan_max_code);
    prev_in_x  = CODE_X_W'(prev_inlet_q);
    prev_out_x = CODE_X_W'(prev_outlet_q);

    err    = (bot_x < floor_x) || (top_x < floor_x);
    excess = top_x - setp_x;
    delta  = top_x - ptop_x;
    spread = top_x - bot_x;
    growth = spread - (ptop_x - pbot_x);

    if (excess <= calc_t'(0)) begin
      inl  = '0;
      outl = '0;
    end else begin
      inl  = (prev_inlet_q == '0) ? on_x : prev_in_x;
      outl = (prev_outlet_q == '0) ? on_x : prev_out_x;

      if (excess > over_x) outl = outl + CODE_X_W'(1);

      if (delta > trend_x) begin
        outl = outl + CODE_X_W'(1);
      end else if (delta < -trend_x) begin
        if (outl > on_x) outl = outl - CODE_X_W'(1);
      end

      // prev code, not the restarted one, gates both inlet moves
      if (spread > shigh_x) begin
        if (prev_in_x >= on_x && growth > trend_x) inl = inl + CODE_X_W'(1);
      end else if (spread < slow_x) begin
        if (prev_in_x > on_x) inl = inl - CODE_X_W'(1);
      end
    end

    if (inl > max_x) inl = max_x;
    if (outl > max_x) outl = max_x;

    inlet_new  = CODE_W'(inl);
    outlet_new = CODE_W'(outl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_top_q <= in_i.top_temp;
      s1_bot_q <= in_i.bottom_temp;
    end
  end

  // Update controller state only on a good beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_top_q    <= '0;
      prev_bot_q    <= '0;
      prev_inlet_q  <= '0;
      prev_outlet_q <= '0;
    end else if (adv && !err) begin
      prev_top_q    <= TEMP_BITS'(s1_top_q);
      prev_bot_q    <= TEMP_BITS'(s1_bot_q);
      prev_inlet_q  <= inlet_new;
      prev_outlet_q <= outlet_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_err_q <= err;
      if (err) begin
        out_inlet_q      <= prev_inlet_q;
        out_outlet_q     <= prev_outlet_q;
        out_inlet_chg_q  <= 1'b0;
        out_outlet_chg_q <= 1'b0;
      end else begin
        out_inlet_q      <= inlet_new;
        out_outlet_q     <= outlet_new;
        out_inlet_chg_q  <= (inlet_new != prev_inlet_q);
        out_outlet_chg_q <= (outlet_new != prev_outlet_q);
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.inlet_code     = out_inlet_q;
  assign out_o.outlet_code    = out_outlet_q;
  assign out_o.inlet_changed  = out_inlet_chg_q;
  assign out_o.outlet_changed = out_outlet_chg_q;
  assign out_o.sensor_error   = out_err_q;

endmodule

/* hw/rtl/enclosure_fan_controller_unit.sv */
// Enclosure fan controller: each input beat carries a top and bottom temperature in
// hundredths of a degree and yields one result beat with the new inlet and outlet fan
// codes, per-fan change flags and a sensor error flag. A new beat is taken every clock
// unless a stalled receiver holds a result; a beat passes the input register, then the
// result register, where the stored readings and fan codes are updated. The user writes
// settings over the APB port at byte address 4*index only while no beat is in flight,
// not enforced by the block; a sensor error returns stored codes, all state untouched.
module enclosure_fan_controller_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  efc_in_if.sink                      in_i,
  efc_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [efc_pkg::APB_AW-1:0]  paddr,
  input  logic [efc_pkg::APB_DW-1:0]  pwdata,
  output logic [efc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import efc_pkg::*;

  efc_cfg_t cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint     <= RST_SETPOINT;
      cfg_q.fan_on_code  <= RST_FAN_ON_CODE;
      cfg_q.fan_max_code <= RST_FAN_MAX_CODE;
      cfg_q.sensor_floor <= RST_SENSOR_FLOOR;
      cfg_q.trend_step   <= RST_TREND_STEP;
      cfg_q.over_margin  <= RST_OVER_MARGIN;
      cfg_q.spread_high  <= RST_SPREAD_HIGH;
      cfg_q.spread_low   <= RST_SPREAD_LOW;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSetpoint:    cfg_q.setpoint     <= temp_t'(pwdata[TEMP_W-1:0]);
        RegFanOnCode:   cfg_q.fan_on_code  <= pwdata[CODE_W-1:0];
        RegFanMaxCode:  cfg_q.fan_max_code <= pwdata[CODE_W-1:0];
        RegSensorFloor: cfg_q.sensor_floor <= temp_t'(pwdata[TEMP_W-1:0]);
        RegTrendStep:   cfg_q.trend_step   <= pwdata[THR_W-1:0];
        RegOverMargin:  cfg_q.over_margin  <= pwdata[THR_W-1:0];
        RegSpreadHigh:  cfg_q.spread_high  <= pwdata[THR_W-1:0];
        RegSpreadLow:   cfg_q.spread_low   <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSetpoint:    prdata = APB_DW'(unsigned'(cfg_q.setpoint));
      RegFanOnCode:   prdata = APB_DW'(cfg_q.fan_on_code);
      RegFanMaxCode:  prdata = APB_DW'(cfg_q.fan_max_code);
      RegSensorFloor: prdata = APB_DW'(unsigned'(cfg_q.sensor_floor));
      RegTrendStep:   prdata = APB_DW'(cfg_q.trend_step);
      RegOverMargin:  prdata = APB_DW'(cfg_q.over_margin);
      RegSpreadHigh:  prdata = APB_DW'(cfg_q.spread_high);
      RegSpreadLow:   prdata = APB_DW'(cfg_q.spread_low);
      default:        prdata = '0;
    endcase
  end

  efc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

/* bench/fan_code_checker.sv */
module fan_code_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  efc_in_if                           in_i,
  efc_out_if                          out_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [efc_pkg::APB_AW-1:0]  paddr_i,
  input  logic [efc_pkg::APB_DW-1:0]  pwdata_i,
  input  logic                        pready_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  import efc_pkg::*;

  typedef struct packed {
    code_t inlet_code;
    code_t outlet_code;
    logic  inlet_changed;
    logic  outlet_changed;
    logic  sensor_error;
  } fan_codes_t;

  // Settings as last written over the register port
  temp_t set_point;
  code_t on_code;
  code_t max_code;
  temp_t sensor_floor;
  thr_t  trend_step;
  thr_t  over_margin;
  thr_t  spread_high;
  thr_t  spread_low;

  prev_temp_t last_top;
  prev_temp_t last_bottom;
  code_t      last_inlet;
  code_t      last_outlet;

  fan_codes_t  codes_due[$];
  int unsigned fails;

  function automatic fan_codes_t next_fan_codes(temp_t top_t, temp_t bot_t);
    int top, bot, ptop, pbot, flo, setp;
    int on_c, max_c, trend, over, shigh, slow, prev_in;
    int inl, outl, d, spread;
    fan_codes_t r;
    top     = top_t;
    bot     = bot_t;
    ptop    = last_top;
    pbot    = last_bottom;
    flo     = sensor_floor;
    setp    = set_point;
    on_c    = on_code;
    max_c   = max_code;
    trend   = trend_step;
    over    = over_margin;
    shigh   = spread_high;
    slow    = spread_low;
    prev_in = last_inlet;

    // A bad reading reports the stored codes and leaves everything untouched
    if (top < flo || bot < flo) begin
      r.inlet_code     = last_inlet;
      r.outlet_code    = last_outlet;
      r.inlet_changed  = 1'b0;
      r.outlet_changed = 1'b0;
      r.sensor_error   = 1'b1;
      return r;
    end

    if (top <= setp) begin
      inl  = 0;
      outl = 0;
    end else begin
      inl  = last_inlet;
      outl = last_outlet;
      if (outl == 0) outl = on_c;
      if (inl == 0) inl = on_c;
      if (top - setp > over) outl++;
      d = top - ptop;
      if (d > trend) begin
        outl++;
      end else if (d < -trend) begin
        if (outl > on_c) outl--;
      end
      // Inlet follows the spread, gated on the code held before this beat
      spread = top - bot;
      if (spread > shigh) begin
        if (prev_in >= on_c && spread - (ptop - pbot) > trend) inl++;
      end else if (spread < slow) begin
        if (prev_in > on_c) inl--;
      end
    end

    if (inl > max_c) inl = max_c;
    if (outl > max_c) outl = max_c;

    r.inlet_code     = code_t'(inl);
    r.outlet_code    = code_t'(outl);
    r.inlet_changed  = (code_t'(inl) != last_inlet);
    r.outlet_changed = (code_t'(outl) != last_outlet);
    r.sensor_error   = 1'b0;

    last_top    = prev_temp_t'(top);
    last_bottom = prev_temp_t'(bot);
    last_inlet  = code_t'(inl);
    last_outlet = code_t'(outl);
    return r;
  endfunction

  function automatic void check_field(string field, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fan_codes_t due;
    if (!rst_ni) begin
      set_point    = RST_SETPOINT;
      on_code      = RST_FAN_ON_CODE;
      max_code     = RST_FAN_MAX_CODE;
      sensor_floor = RST_SENSOR_FLOOR;
      trend_step   = RST_TREND_STEP;
      over_margin  = RST_OVER_MARGIN;
      spread_high  = RST_SPREAD_HIGH;
      spread_low   = RST_SPREAD_LOW;
      last_top     = '0;
      last_bottom  = '0;
      last_inlet   = '0;
      last_outlet  = '0;
      codes_due.delete();
      fails = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (codes_due.size() == 0) begin
          $error("result beat with no expectation pending");
          fails++;
        end else begin
          due = codes_due.pop_front();
          check_field("inlet_code", due.inlet_code, out_i.inlet_code);
          check_field("outlet_code", due.outlet_code, out_i.outlet_code);
          check_field("inlet_changed", due.inlet_changed, out_i.inlet_changed);
          check_field("outlet_changed", due.outlet_changed, out_i.outlet_changed);
          check_field("sensor_error", due.sensor_error, out_i.sensor_error);
        end
      end

      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[APB_AW-1:2]))
          RegSetpoint:    set_point    = temp_t'(pwdata_i[TEMP_W-1:0]);
          RegFanOnCode:   on_code      = pwdata_i[CODE_W-1:0];
          RegFanMaxCode:  max_code     = pwdata_i[CODE_W-1:0];
          RegSensorFloor: sensor_floor = temp_t'(pwdata_i[TEMP_W-1:0]);
          RegTrendStep:   trend_step   = pwdata_i[THR_W-1:0];
          RegOverMargin:  over_margin  = pwdata_i[THR_W-1:0];
          RegSpreadHigh:  spread_high  = pwdata_i[THR_W-1:0];
          RegSpreadLow:   spread_low   = pwdata_i[THR_W-1:0];
          default: ;
        endcase
      end

      if (in_i.valid && in_i.ready) begin
        codes_due.push_back(next_fan_codes(in_i.top_temp, in_i.bottom_temp));
      end
    end
    fail_count_o <= fails;
    pending_o    <= codes_due.size();
  end

endmodule

/* bench/enclosure_fan_controller_unit_test.sv */
module enclosure_fan_controller_unit_test;
  import efc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned RANDOM_PER_PHASE = 225;
  localparam int unsigned PHASES           = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic        recv_ready     = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;
  int unsigned fail_count;
  int unsigned codes_pending;

  // Shapes the random readings around the active setpoint
  int stim_setpoint = 2100;
  int walk_top      = 2100;
  int walk_spread   = 0;

  efc_in_if  in_if ();
  efc_out_if out_if ();

  assign out_if.ready = recv_ready;

  enclosure_fan_controller_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fan_code_checker code_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (codes_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    recv_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int clip15(int v);
    if (v > 16383) return 16383;
    if (v < -16384) return -16384;
    return v;
  endfunction

  task automatic push_sample(input int top, input int bot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.top_temp    <= temp_t'(top);
    in_if.bottom_temp <= temp_t'(bot);
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic push_random_sample();
    int pick;
    int top, bot;
    pick = $urandom_range(99);
    if (pick < 82) begin
      // Random walk near the setpoint with an occasional jump
      if (pick < 5) walk_top += int'($urandom_range(4000)) - 2000;
      else walk_top += int'($urandom_range(160)) - 80;
      if (walk_top > stim_setpoint + 1500 || walk_top < stim_setpoint - 500) begin
        walk_top = stim_setpoint + int'($urandom_range(800)) - 200;
      end
      walk_spread += int'($urandom_range(120)) - 60;
      if (walk_spread > 1500 || walk_spread < -200) walk_spread = $urandom_range(1000);
      top = clip15(walk_top);
      bot = clip15(walk_top - walk_spread);
    end else if (pick < 94) begin
      top = int'($urandom_range(25599)) - 12800;
      bot = int'($urandom_range(25599)) - 12800;
    end else begin
      top = int'($urandom_range(32767)) - 16384;
      bot = int'($urandom_range(32767)) - 16384;
    end
    push_sample(top, bot);
  endtask

  // Drop valid and hold until every result beat has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (codes_pending != 0);
  endtask

  task automatic write_settings(input logic [APB_DW-1:0] vals [REG_N]);
    for (int i = 0; i < REG_N; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx_e'(i), 2'b00};
      pwdata  <= vals[i];
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [APB_DW-1:0] regs_v [REG_N];
    in_if.valid       = 1'b0;
    in_if.top_temp    = '0;
    in_if.bottom_temp = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase

      case (phase)
        1: regs_v = '{32'(-12800), 32'd0, 32'd255, 32'(-12800), 32'd0, 32'd0, 32'd0, 32'd0};
        2: regs_v = '{32'd12799, 32'd255, 32'd0, 32'd12799,
                      32'd12799, 32'd12799, 32'd12799, 32'd12799};
        3: regs_v = '{32'd2100, 32'd100, 32'd200, 32'(-9500), 32'd10, 32'd200, 32'd300, 32'd100};
        4: begin
          regs_v[RegSetpoint]    = 32'(int'($urandom_range(25599)) - 12800);
          regs_v[RegFanOnCode]   = $urandom_range(255);
          regs_v[RegFanMaxCode]  = $urandom_range(255);
          regs_v[RegSensorFloor] = 32'(int'($urandom_range(25599)) - 12800);
          regs_v[RegTrendStep]   = $urandom_range(200);
          regs_v[RegOverMargin]  = $urandom_range(12799);
          regs_v[RegSpreadHigh]  = $urandom_range(12799);
          regs_v[RegSpreadLow]   = $urandom_range(12799);
        end
        5: for (int i = 0; i < REG_N; i++) regs_v[i] = $urandom();
        6: regs_v = '{32'd0, 32'd250, 32'd100, 32'(-12800), 32'd50, 32'd100, 32'd200, 32'd400};
        7: regs_v = '{32'(RST_SETPOINT), 32'(RST_FAN_ON_CODE), 32'(RST_FAN_MAX_CODE),
                      32'(RST_SENSOR_FLOOR), 32'(RST_TREND_STEP), 32'(RST_OVER_MARGIN),
                      32'(RST_SPREAD_HIGH), 32'(RST_SPREAD_LOW)};
        default: ;
      endcase

      // The first phase runs on the settings left by reset
      if (phase != 0) begin
        write_settings(regs_v);
        stim_setpoint = int'(temp_t'(regs_v[RegSetpoint][TEMP_W-1:0]));
      end
      walk_top    = stim_setpoint;
      walk_spread = 0;

      if (phase == 0) begin
        push_sample(0, 0);
        push_sample(2101, 2000);      // first step above setpoint
        push_sample(2500, 1000);      // well over, rising, wide spread
        push_sample(2500, 1000);
        push_sample(2400, 2300);      // falling, narrow spread
        push_sample(2440, 2300);
        push_sample(2700, 1000);
        push_sample(-9501, 0);        // top below floor
        push_sample(0, -9501);        // bottom below floor
        push_sample(-9500, -9500);    // exactly at floor
        push_sample(2100, 2100);      // exactly at setpoint
        push_sample(12799, -9500);
        push_sample(12799, 12799);
        push_sample(-12800, -12800);
        push_sample(16383, -16384);
        push_sample(-16384, 16383);
        push_sample(3000, 2990);
        push_sample(2950, 2000);
        push_sample(2960, 1500);
        push_sample(2200, 2190);
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) push_random_sample();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && codes_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
